### hdl/log_record_deframer_defines.svh
// Assertion macros for the log record deframer.
// Included by the top level; each macro expects a clock named aclk and a reset named aresetn.
`ifndef LOG_RECORD_DEFRAMER_DEFINES_SVH
`define LOG_RECORD_DEFRAMER_DEFINES_SVH

// Checked on every rising edge of aclk, suspended while reset is asserted.
`define LRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, including during reset.
`define LRD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/lrd_pkg.sv
// Shared constants and types for the log record deframer.
// Used by lrd_parser and log_record_deframer; depends on nothing else.
package lrd_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int HDR_CNT_W    = 5;
    localparam int FIELD_IDX_W  = 3;
    localparam int TDATA_W      = 152;

    localparam logic [FIELD_IDX_W-1:0] FIELD_LENGTH  = 3'd0;
    localparam logic [FIELD_IDX_W-1:0] FIELD_PROCESS = 3'd1;
    localparam logic [FIELD_IDX_W-1:0] FIELD_THREAD  = 3'd2;
    localparam logic [FIELD_IDX_W-1:0] FIELD_SECONDS = 3'd3;

    localparam logic KIND_PAYLOAD    = 1'b0;
    localparam logic KIND_END_MARKER = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic        last_of_record;
        logic [15:0] record_length;
        logic [31:0] process_id;
        logic [31:0] thread_id;
        logic [31:0] time_seconds;
        logic [31:0] time_nanoseconds;
    } lrd_result_t;

endpackage

### hdl/lrd_parser.sv
// Header and payload parser of the log record deframer: holds the parse state
// and forms the result for each byte it steps on. Depends on lrd_pkg.
module lrd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          data_byte,
    output logic                emit,
    output lrd_pkg::lrd_result_t result
);
    import lrd_pkg::*;

    logic                 in_payload_reg, in_payload_next;
    logic [HDR_CNT_W-1:0] header_count_reg, header_count_next;
    logic [15:0]          payload_count_reg, payload_count_next;
    logic [15:0]          held_length_reg, held_length_next;
    logic [31:0]          held_process_reg, held_process_next;
    logic [31:0]          held_thread_reg, held_thread_next;
    logic [31:0]          held_seconds_reg, held_seconds_next;
    logic [31:0]          held_nanoseconds_reg, held_nanoseconds_next;

    logic [FIELD_IDX_W-1:0] field_idx;
    logic [1:0]             sub_idx;
    logic                   header_last;
    logic [16:0]            payload_count_inc;
    logic                   payload_last;

    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] pos,
                                             input logic [7:0] b);
        logic [31:0] res;
        res = word;
        for (int i = 0; i < 4; i++) begin
            if (pos == 2'(i)) begin
                res[i*8 +: 8] = b;
            end
        end
        return res;
    endfunction

    assign field_idx         = header_count_reg[HDR_CNT_W-1:2];
    assign sub_idx           = header_count_reg[1:0];
    assign header_last       = header_count_reg >= HDR_CNT_W'(HEADER_BYTES - 1);
    assign payload_count_inc = {1'b0, payload_count_reg} + 17'd1;
    assign payload_last      = payload_count_inc >= {1'b0, held_length_reg};

    always_comb begin
        in_payload_next       = in_payload_reg;
        header_count_next     = header_count_reg;
        payload_count_next    = payload_count_reg;
        held_length_next      = held_length_reg;
        held_process_next     = held_process_reg;
        held_thread_next      = held_thread_reg;
        held_seconds_next     = held_seconds_reg;
        held_nanoseconds_next = held_nanoseconds_reg;
        emit                  = 1'b0;
        result.kind           = KIND_PAYLOAD;
        result.payload_byte   = data_byte;
        result.last_of_record = payload_last;

        if (!in_payload_reg) begin
            unique case (field_idx)
                FIELD_LENGTH: begin
                    if (!sub_idx[1]) begin
                        held_length_next = 16'(put_byte({16'd0, held_length_reg}, sub_idx,
                                                        data_byte));
                    end
                end
                FIELD_PROCESS: held_process_next = put_byte(held_process_reg, sub_idx, data_byte);
                FIELD_THREAD:  held_thread_next  = put_byte(held_thread_reg, sub_idx, data_byte);
                FIELD_SECONDS: held_seconds_next = put_byte(held_seconds_reg, sub_idx, data_byte);
                default: begin
                    held_nanoseconds_next = put_byte(held_nanoseconds_reg, sub_idx, data_byte);
                end
            endcase
            result.kind           = KIND_END_MARKER;
            result.payload_byte   = 8'd0;
            result.last_of_record = 1'b1;
            if (header_last) begin
                header_count_next  = '0;
                payload_count_next = '0;
                if (held_length_next == 16'd0) begin
                    emit = 1'b1;
                end else begin
                    in_payload_next = 1'b1;
                end
            end else begin
                header_count_next = header_count_reg + HDR_CNT_W'(1);
            end
        end else begin
            emit = 1'b1;
            if (payload_last) begin
                in_payload_next    = 1'b0;
                payload_count_next = '0;
                header_count_next  = '0;
            end else begin
                payload_count_next = payload_count_inc[15:0];
            end
        end

        result.record_length    = held_length_next;
        result.process_id       = held_process_next;
        result.thread_id        = held_thread_next;
        result.time_seconds     = held_seconds_next;
        result.time_nanoseconds = held_nanoseconds_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg       <= 1'b0;
            header_count_reg     <= '0;
            payload_count_reg    <= '0;
            held_length_reg      <= '0;
            held_process_reg     <= '0;
            held_thread_reg      <= '0;
            held_seconds_reg     <= '0;
            held_nanoseconds_reg <= '0;
        end else if (step) begin
            in_payload_reg       <= in_payload_next;
            header_count_reg     <= header_count_next;
            payload_count_reg    <= payload_count_next;
            held_length_reg      <= held_length_next;
            held_process_reg     <= held_process_next;
            held_thread_reg      <= held_thread_next;
            held_seconds_reg     <= held_seconds_next;
            held_nanoseconds_reg <= held_nanoseconds_next;
        end
    end

endmodule

### hdl/log_record_deframer.sv
// Top level of the log record deframer: input handshake, cancel register and
// output register around lrd_parser. Depends on lrd_pkg and the defines header.
//
//   Channel   Direction  Transaction
//   s_axis    in         one raw byte of the log stream
//   m_axis    out        one payload byte or end-of-empty-record marker
//   cfg       in         write of the cancel register
//
// Each byte is parsed in the cycle it is accepted; its result, if any, appears
// on the master side in the cycle after. One byte per cycle is sustained while
// m_tready is high; a stalled result holds in the output register and the
// slave side stalls only while that register is full and not taken.
// Reset (synchronous, active low) clears the parse state and the cancel bit.
`include "log_record_deframer_defines.svh"

module log_record_deframer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // data_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [lrd_pkg::TDATA_W-1:0] m_tdata,  // payload_byte, record_length, process_id,
                                                  // thread_id, time_seconds, time_nanoseconds
    output logic [0:0]                 m_tuser,   // kind
    output logic                       m_tlast,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data
);
    import lrd_pkg::*;

    logic        cancelled_reg;
    logic        m_valid_reg;
    lrd_result_t result_reg;
    lrd_result_t result;
    logic        emit;
    logic        accept;
    logic        step;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign step     = accept && !cancelled_reg;

    lrd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (s_tdata),
        .emit      (emit),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cancelled_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            cancelled_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            result_reg <= result;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = result_reg.kind;
    assign m_tlast    = result_reg.last_of_record;
    assign m_tdata    = {result_reg.time_nanoseconds, result_reg.time_seconds,
                         result_reg.thread_id, result_reg.process_id,
                         result_reg.record_length, result_reg.payload_byte};

    `LRD_ASSERT(a_marker_form, m_tvalid && m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0, "end marker must be last and carry a zero byte")
    `LRD_ASSERT(a_cancel_drops, accept && cancelled_reg && m_tready |=> !m_tvalid, "byte taken while cancelled produced a result")
    `LRD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

### tb/log_record_deframer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for log_record_deframer: watches the byte, result and cancel ports,
// deframes on its own every byte accepted while not cancelled and compares each result it expects.
// Depends on lrd_pkg for the result layout, the field indexes and the kind codes.

module log_record_deframer_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [lrd_pkg::TDATA_W-1:0] m_tdata,
    input  logic [0:0]                  m_tuser,
    input  logic                        m_tlast,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    output int                          fail_count,
    output int                          outstanding,
    output int                          results_checked
);

    logic                 cancel_on;
    logic                 in_payload;
    logic [4:0]           header_pos;
    logic [15:0]          payload_pos;
    lrd_pkg::lrd_result_t held;
    lrd_pkg::lrd_result_t expected_results[$];
    lrd_pkg::lrd_result_t got;
    lrd_pkg::lrd_result_t want;
    int                   errors = 0;
    int                   checked = 0;

    task automatic deframe_byte(input logic [7:0] b);
        lrd_pkg::lrd_result_t r;
        if (cancel_on) return;
        if (!in_payload) begin
            case (header_pos[4:2])
                lrd_pkg::FIELD_LENGTH: begin
                    if (!header_pos[1]) held.record_length[header_pos[0]*8 +: 8] = b;
                end
                lrd_pkg::FIELD_PROCESS: held.process_id[header_pos[1:0]*8 +: 8] = b;
                lrd_pkg::FIELD_THREAD:  held.thread_id[header_pos[1:0]*8 +: 8] = b;
                lrd_pkg::FIELD_SECONDS: held.time_seconds[header_pos[1:0]*8 +: 8] = b;
                default:                held.time_nanoseconds[header_pos[1:0]*8 +: 8] = b;
            endcase
            if (header_pos + 1 >= lrd_pkg::HEADER_BYTES) begin
                header_pos = '0;
                payload_pos = '0;
                if (held.record_length == 16'd0) begin
                    r = held;
                    r.kind = lrd_pkg::KIND_END_MARKER;
                    r.payload_byte = 8'h00;
                    r.last_of_record = 1'b1;
                    expected_results.push_back(r);
                end else begin
                    in_payload = 1'b1;
                end
            end else begin
                header_pos = header_pos + 5'd1;
            end
        end else begin
            r = held;
            r.kind = lrd_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            r.last_of_record = ((payload_pos + 17'd1) >= held.record_length);
            expected_results.push_back(r);
            if (r.last_of_record) begin
                in_payload = 1'b0;
                payload_pos = '0;
                header_pos = '0;
            end else begin
                payload_pos = payload_pos + 16'd1;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cancel_on = 1'b0;
            in_payload = 1'b0;
            header_pos = '0;
            payload_pos = '0;
            held = '0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata[7:0], m_tlast, m_tdata[23:8], m_tdata[55:24],
                       m_tdata[87:56], m_tdata[119:88], m_tdata[151:120]};
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%t: unexpected result, expected none, actual %h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got !== want) begin
                        errors++;
                        if (errors <= 30)
                            $display({"%t: result mismatch (expected/actual) kind %0d/%0d ",
                                      "byte %h/%h last %0d/%0d length %h/%h pid %h/%h ",
                                      "tid %h/%h sec %h/%h nsec %h/%h"}, $time,
                                     want.kind, got.kind, want.payload_byte, got.payload_byte,
                                     want.last_of_record, got.last_of_record,
                                     want.record_length, got.record_length,
                                     want.process_id, got.process_id,
                                     want.thread_id, got.thread_id,
                                     want.time_seconds, got.time_seconds,
                                     want.time_nanoseconds, got.time_nanoseconds);
                    end
                end
            end
            if (s_tvalid && s_tready) deframe_byte(s_tdata);
            if (cfg_wr_en) cancel_on = cfg_wr_data;
        end
        fail_count <= errors;
        outstanding <= expected_results.size();
        results_checked <= checked;
    end

endmodule

### tb/log_record_deframer_tb.sv
`timescale 1ns / 1ps
// Top of the log_record_deframer testbench: clock, reset, byte stimulus, result
// back-pressure, cancel writes and the verdict. Needs lrd_pkg, the block and
// log_record_deframer_checker.

module log_record_deframer_tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int TARGET_BYTES = 450;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata = 8'h00;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [lrd_pkg::TDATA_W-1:0] m_tdata;
    logic [0:0]                  m_tuser;
    logic                        m_tlast;
    logic                        cfg_wr_en = 1'b0;
    logic                        cfg_wr_data = 1'b0;

    int fail_count;
    int outstanding;
    int results_checked;
    int bytes_sent = 0;
    int dropped_bytes = 0;
    int records_sent = 0;
    int empty_records = 0;
    int idle_cycles = 0;
    int sink_stall = 0;
    int stall_draw;
    bit src_burst = 1'b0;
    bit sink_burst = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    log_record_deframer DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    log_record_deframer_checker u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count),
        .outstanding(outstanding),
        .results_checked(results_checked)
    );

    // Each result draws its own stall; bursts run without any.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_stall <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                if ($urandom_range(0, 31) == 0) sink_burst <= !sink_burst;
                stall_draw = sink_burst ? 0 : $urandom_range(0, 12);
                if (stall_draw > 0) begin
                    m_tready <= 1'b0;
                    sink_stall <= stall_draw;
                end
            end
        end else if (sink_stall > 1) begin
            sink_stall <= sink_stall - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Header bytes give no result, so a short pause follows the last expected result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cancel(input logic value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic cancel_interlude();
        int n;
        wait_idle();
        write_cancel(1'b1);
        n = $urandom_range(1, 6);
        repeat (n) begin
            send_byte(pick_byte());
            dropped_bytes++;
        end
        wait_idle();
        write_cancel(1'b0);
    endtask

    task automatic send_record(input logic [15:0] len, input logic [15:0] pad,
                               input logic [31:0] pid, input logic [31:0] tid,
                               input logic [31:0] sec, input logic [31:0] nsec,
                               input int cut);
        logic [159:0] header;
        int i;
        header = {nsec, sec, tid, pid, pad, len};
        records_sent++;
        if (len == 16'd0) empty_records++;
        for (i = 0; i < lrd_pkg::HEADER_BYTES + len; i++) begin
            if (i == cut) cancel_interlude();
            send_byte((i < lrd_pkg::HEADER_BYTES) ? header[i*8 +: 8] : pick_byte());
            bytes_sent++;
        end
    endtask

    initial begin
        int len;
        int cut;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        write_cancel(1'b0);

        send_record(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, -1);

        while (bytes_sent < TARGET_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1:    len = 0;
                2, 3, 4: len = $urandom_range(1, 4);
                5, 6, 7: len = $urandom_range(5, 24);
                default: len = $urandom_range(25, 60);
            endcase
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 19 + len) : -1;
            src_burst = ($urandom_range(0, 3) == 0);
            send_record(16'(len), 16'($urandom), $urandom, $urandom, $urandom, $urandom, cut);
        end

        wait_idle();
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes in %0d records (%0d empty), %0d dropped",
                 bytes_sent, records_sent, empty_records, dropped_bytes);
        $display("while cancelled; %0d results checked on the master side.", results_checked);
        if (outstanding != 0)
            $display("%t: %0d expected results never arrived", $time, outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
